// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl, clocked on clk_i and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CDS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define CDS_ASSERT_NEVER(name, cond, msg) \
  `CDS_ASSERT(name, !(cond), msg)

`endif

// ----- rtl/cds_pkg.sv -----
package cds_pkg;

  localparam int unsigned DEF_VALUE_WIDTH = 32;
  localparam int unsigned DEF_FRAC_BITS   = 16;
  localparam int unsigned RATE_WIDTH      = 24;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

endpackage

// ----- rtl/cds_in_if.sv -----
interface cds_in_if #(
  parameter int unsigned VALUE_WIDTH = cds_pkg::DEF_VALUE_WIDTH
);
  logic                               valid;
  logic                               ready;
  logic signed [VALUE_WIDTH-1:0]      current_position;
  logic signed [VALUE_WIDTH-1:0]      goal_position;
  logic [cds_pkg::RATE_WIDTH-1:0]     time_step;

  modport source (
    output valid, current_position, goal_position, time_step,
    input  ready
  );

  modport sink (
    input  valid, current_position, goal_position, time_step,
    output ready
  );
endinterface

// ----- rtl/cds_out_if.sv -----
interface cds_out_if #(
  parameter int unsigned VALUE_WIDTH = cds_pkg::DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] new_position;
  logic signed [VALUE_WIDTH-1:0] new_velocity;
  logic                          snapped;

  modport source (
    output valid, new_position, new_velocity, snapped,
    input  ready
  );

  modport sink (
    input  valid, new_position, new_velocity, snapped,
    output ready
  );
endinterface

// ----- rtl/critically_damped_smoother_core.sv -----
// Critically damped smoother: each transfer on item_i brings a position, a goal and a time
// step; one result leaves on result_o with the smoothed position, the velocity now held and a
// snap flag. Everything runs on one shared 32x32 multiplier (a 64x64 product takes an operand
// load, four partial products, then a saturating finish and a write-back) and a restoring
// divider that yields one quotient bit per cycle. An item takes 10 products plus FRAC_BITS+1
// divide steps plus a hand-over (take, overshoot check, output load); the OT and VN products
// are skipped when the overshoot snap fires; with angular rate zero the goal goes from
// the take straight to the output load. item_i is not ready while an item is being worked
// on; a finished result waits in the output register, so the next item can be taken before
// it is collected, and an item that finishes while that register is still full waits for it
// to drain.
// Write angular_rate only while the block is idle.
`include "assert_macros.svh"

module critically_damped_smoother_core #(
  parameter int unsigned VALUE_WIDTH = cds_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRAC_BITS   = cds_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cds_pkg::RATE_WIDTH-1:0] cfg_wdata_i,
  cds_in_if.sink                         item_i,
  cds_out_if.source                      result_o
);

  localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] C_048  = ((64'd48 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] C_0235 = ((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic signed [63:0] VAL_MAX = $signed({1'b0, {63{1'b1}}} >> (64 - VALUE_WIDTH));
  localparam logic signed [63:0] VAL_MIN = ~VAL_MAX;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_CHK  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    PH_LD, PH_P0, PH_P1, PH_P2, PH_P3, PH_FIN, PH_WB
  } phase_e;

  typedef enum logic [3:0] {
    OP_X, OP_X2, OP_X3, OP_M1, OP_M2, OP_OD, OP_TMP, OP_P, OP_OT, OP_VN
  } op_e;

  function automatic logic signed [VALUE_WIDTH-1:0] sat_val(input logic signed [63:0] v);
    if (v > VAL_MAX) begin
      return VALUE_WIDTH'(VAL_MAX);
    end
    if (v < VAL_MIN) begin
      return VALUE_WIDTH'(VAL_MIN);
    end
    return VALUE_WIDTH'(v);
  endfunction

  state_e state_q;
  phase_e ph_q;
  op_e    op_q;
  logic [CNT_W-1:0] cnt_q;
  logic [cds_pkg::RATE_WIDTH-1:0] omega_q;
  logic signed [VALUE_WIDTH-1:0] vel_q;
  logic out_valid_q;

  logic signed [VALUE_WIDTH-1:0] cur_q, goal_q, pos_q;
  logic signed [VALUE_WIDTH-1:0] out_pos_q, out_vel_q;
  logic out_snap_q, snap_q;
  logic [cds_pkg::RATE_WIDTH-1:0] dt_q;
  logic signed [63:0] diff_q, x_q, x2_q, x3_q, den_q, d_q, a_q, s_q, temp_q, mres_q;
  logic [63:0] rem_q, ua_q, ub_q;
  logic sign_q;
  logic [127:0] acc_q;

  logic in_xfer, out_xfer, out_free, snap_now, div_ge, div_last;
  logic signed [63:0] opa, opb, mres_d, vel64;
  logic [31:0] a_half, b_half;
  logic [63:0] pp, rem_sh;
  logic [6:0] pp_sh;
  logic [127:0] fin_r;

  assign in_xfer  = item_i.valid && item_i.ready;
  assign out_xfer = result_o.valid && result_o.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE);

  assign result_o.valid        = out_valid_q;
  assign result_o.new_position = out_pos_q;
  assign result_o.new_velocity = out_vel_q;
  assign result_o.snapped      = out_snap_q;

  assign vel64    = 64'(vel_q);
  assign snap_now = ((goal_q > cur_q) == (pos_q > goal_q));

  // operand routing into the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (op_q)
      OP_X:    begin opa = 64'(omega_q); opb = 64'(dt_q); end
      OP_X2:   begin opa = x_q;          opb = x_q;       end
      OP_X3:   begin opa = x2_q;         opb = x_q;       end
      OP_M1:   begin opa = C_048;        opb = x2_q;      end
      OP_M2:   begin opa = C_0235;       opb = x3_q;      end
      OP_OD:   begin opa = 64'(omega_q); opb = diff_q;    end
      OP_TMP:  begin opa = a_q;          opb = 64'(dt_q); end
      OP_P:    begin opa = s_q;          opb = d_q;       end
      OP_OT:   begin opa = 64'(omega_q); opb = temp_q;    end
      OP_VN:   begin opa = a_q;          opb = d_q;       end
      default: begin opa = '0;           opb = '0;        end
    endcase
  end

  // partial product select: low/low, low/high, high/low, high/high
  always_comb begin
    a_half = ua_q[31:0];
    b_half = ub_q[31:0];
    pp_sh  = 7'd0;
    case (ph_q)
      PH_P1: begin b_half = ub_q[63:32]; pp_sh = 7'd32; end
      PH_P2: begin a_half = ua_q[63:32]; pp_sh = 7'd32; end
      PH_P3: begin a_half = ua_q[63:32]; b_half = ub_q[63:32]; pp_sh = 7'd64; end
      default: ;
    endcase
  end

  assign pp = a_half * b_half;

  // drop the fraction bits, then clamp the magnitude into the signed 64-bit range
  assign fin_r = acc_q >> FRAC_BITS;
  always_comb begin
    if (sign_q) begin
      if ((|fin_r[127:64]) || (fin_r[63:0] > 64'(cds_pkg::S64_MIN))) begin
        mres_d = cds_pkg::S64_MIN;
      end else begin
        mres_d = -$signed(fin_r[63:0]);
      end
    end else begin
      if (|fin_r[127:63]) begin
        mres_d = cds_pkg::S64_MAX;
      end else begin
        mres_d = $signed(fin_r[63:0]);
      end
    end
  end

  assign rem_sh   = {rem_q[62:0], 1'b0};
  assign div_ge   = (rem_sh >= $unsigned(den_q));
  assign div_last = (cnt_q == CNT_W'(FRAC_BITS));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_LD;
      op_q        <= OP_X;
      cnt_q       <= '0;
      omega_q     <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        omega_q <= cfg_wdata_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (omega_q == '0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_MUL;
              op_q    <= OP_X;
              ph_q    <= PH_LD;
            end
          end
        end
        ST_MUL: begin
          if (ph_q == PH_WB) begin
            ph_q <= PH_LD;
            case (op_q)
              OP_X:   op_q <= OP_X2;
              OP_X2:  op_q <= OP_X3;
              OP_X3:  op_q <= OP_M1;
              OP_M1:  op_q <= OP_M2;
              OP_M2: begin
                state_q <= ST_DIV;
                cnt_q   <= '0;
              end
              OP_OD:  op_q <= OP_TMP;
              OP_TMP: op_q <= OP_P;
              OP_P:   state_q <= ST_CHK;
              OP_OT:  op_q <= OP_VN;
              OP_VN: begin
                vel_q   <= sat_val(mres_q);
                state_q <= ST_DONE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end else begin
            ph_q <= phase_e'(ph_q + 3'd1);
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (div_last) begin
            state_q <= ST_MUL;
            op_q    <= OP_OD;
            ph_q    <= PH_LD;
          end
        end
        ST_CHK: begin
          if (snap_now) begin
            vel_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_MUL;
            op_q    <= OP_OT;
            ph_q    <= PH_LD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cur_q  <= item_i.current_position;
          goal_q <= item_i.goal_position;
          dt_q   <= item_i.time_step;
          diff_q <= cds_pkg::sat_sub64(64'(item_i.current_position),
                                       64'(item_i.goal_position));
          pos_q  <= item_i.goal_position;
          snap_q <= 1'b0;
        end
      end
      ST_MUL: begin
        case (ph_q)
          PH_LD: begin
            sign_q <= opa[63] ^ opb[63];
            ua_q   <= opa[63] ? 64'(-opa) : 64'(opa);
            ub_q   <= opb[63] ? 64'(-opb) : 64'(opb);
            acc_q  <= '0;
          end
          PH_P0, PH_P1, PH_P2, PH_P3: begin
            acc_q <= acc_q + ({64'd0, pp} << pp_sh);
          end
          PH_FIN: mres_q <= mres_d;
          PH_WB: begin
            case (op_q)
              OP_X: begin
                x_q   <= mres_q;
                den_q <= cds_pkg::sat_add64(ONE_Q, mres_q);
              end
              OP_X2: x2_q  <= mres_q;
              OP_X3: x3_q  <= mres_q;
              OP_M1: den_q <= cds_pkg::sat_add64(den_q, mres_q);
              OP_M2: begin
                den_q <= cds_pkg::sat_add64(den_q, mres_q);
                // quotient never reaches bit FRAC_BITS+1, so start part-way into 2^(2F)
                rem_q <= 64'd1 << (FRAC_BITS - 1);
                d_q   <= '0;
              end
              OP_OD: a_q <= cds_pkg::sat_sub64(vel64, mres_q);
              OP_TMP: begin
                temp_q <= mres_q;
                s_q    <= cds_pkg::sat_add64(diff_q, mres_q);
              end
              OP_P:  pos_q <= sat_val(cds_pkg::sat_add64(64'(goal_q), mres_q));
              OP_OT: a_q   <= cds_pkg::sat_sub64(vel64, mres_q);
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        rem_q <= div_ge ? (rem_sh - $unsigned(den_q)) : rem_sh;
        d_q   <= {d_q[62:0], div_ge};
      end
      ST_CHK: begin
        if (snap_now) begin
          pos_q  <= goal_q;
          snap_q <= 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_pos_q  <= pos_q;
          out_vel_q  <= vel_q;
          out_snap_q <= snap_q;
        end
      end
      default: ;
    endcase
  end

  `CDS_ASSERT(a_busy_after_take, in_xfer |=> !item_i.ready, "ready after an item transfer")
  `CDS_ASSERT(a_snap_clears_vel, (out_valid_q && out_snap_q) |-> (out_vel_q == '0), "snap left velocity")
  `CDS_ASSERT(a_den_floor, (state_q == ST_DIV) |-> ($unsigned(den_q) >= ONE_Q), "denominator below one")
  `CDS_ASSERT(a_quot_bound, $fell(state_q == ST_DIV) |-> ($unsigned(d_q) <= ONE_Q), "decay above one")
  `CDS_ASSERT(a_pass_keeps_vel, (in_xfer && (omega_q == '0)) |=> (vel_q == $past(vel_q)), "pass-through moved velocity")

endmodule

// ----- verif/critically_damped_smoother_core_checker.sv -----
`timescale 1ns / 1ps

module critically_damped_smoother_core_checker #(
  parameter int unsigned VALUE_WIDTH = cds_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRAC_BITS   = cds_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cds_pkg::RATE_WIDTH-1:0] cfg_wdata_i,
  cds_in_if                              item_i,
  cds_out_if                             result_i,
  output int unsigned                    fault_count_o,
  output int unsigned                    outstanding_o
);

  typedef logic signed [63:0] fx_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] position;
    logic signed [VALUE_WIDTH-1:0] velocity;
    logic                          snapped;
  } smooth_result_t;

  localparam fx_t FX_MAX   = {1'b0, {63{1'b1}}};
  localparam fx_t FX_MIN   = {1'b1, {63{1'b0}}};
  localparam fx_t ONE_Q    = fx_t'(1) <<< FRAC_BITS;
  localparam fx_t WORD_MAX = (fx_t'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam fx_t WORD_MIN = -WORD_MAX - 1;
  // cubic coefficients, rounded to the nearest fraction step
  localparam fx_t K_QUAD   = ((fx_t'(48) <<< FRAC_BITS) + 50) / 100;
  localparam fx_t K_CUBE   = ((fx_t'(235) <<< FRAC_BITS) + 500) / 1000;

  fx_t                           held_velocity;
  logic [cds_pkg::RATE_WIDTH-1:0] rate_q;
  smooth_result_t                expected_q[$];

  function automatic fx_t clamp_add(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

  function automatic fx_t clamp_sub(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) - $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

  function automatic fx_t clamp_word(input fx_t v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // full product, magnitude shifted down, then clamped to 64 bits
  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [127:0] prod;
    logic         neg;
    neg   = a[63] ^ b[63];
    mag_a = a[63] ? 64'(-a) : 64'(a);
    mag_b = b[63] ? 64'(-b) : 64'(b);
    prod  = ({64'd0, mag_a} * {64'd0, mag_b}) >> FRAC_BITS;
    if (prod >= (128'd1 << 63)) return neg ? FX_MIN : FX_MAX;
    return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  function automatic smooth_result_t smooth_step(input fx_t cur, input fx_t goal,
                                                 input fx_t dt, input fx_t omega,
                                                 input fx_t vel);
    smooth_result_t r;
    fx_t            x;
    fx_t            x2;
    fx_t            x3;
    fx_t            den;
    fx_t            gain;
    fx_t            diff;
    fx_t            temp;
    fx_t            pos;
    logic [63:0]    gain_u;
    r.snapped = 1'b0;
    if (omega == 0) begin
      r.position = goal[VALUE_WIDTH-1:0];
      r.velocity = vel[VALUE_WIDTH-1:0];
      return r;
    end
    x   = fx_mul(omega, dt);
    x2  = fx_mul(x, x);
    x3  = fx_mul(x2, x);
    den = clamp_add(clamp_add(clamp_add(ONE_Q, x), fx_mul(K_QUAD, x2)), fx_mul(K_CUBE, x3));
    // reciprocal of the cubic, may fall to zero for a large omega*dt
    gain_u = (64'd1 << (2 * FRAC_BITS)) / 64'(den);
    gain   = $signed(gain_u);
    diff   = clamp_sub(cur, goal);
    temp   = fx_mul(clamp_sub(vel, fx_mul(omega, diff)), dt);
    pos    = clamp_word(clamp_add(goal, fx_mul(clamp_add(diff, temp), gain)));
    if ((goal > cur) == (pos > goal)) begin
      r.position = goal[VALUE_WIDTH-1:0];
      r.velocity = '0;
      r.snapped  = 1'b1;
    end else begin
      r.position = pos[VALUE_WIDTH-1:0];
      r.velocity = VALUE_WIDTH'(clamp_word(fx_mul(clamp_sub(vel, fx_mul(omega, temp)), gain)));
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    smooth_result_t want;
    smooth_result_t got;
    if (!rst_ni) begin
      held_velocity = '0;
      rate_q        = '0;
      expected_q.delete();
      fault_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        rate_q = cfg_wdata_i;
      end
      // the result side goes first: a result never belongs to an item taken at the same edge
      if (result_i.valid && result_i.ready) begin
        got.position = result_i.new_position;
        got.velocity = result_i.new_velocity;
        got.snapped  = result_i.snapped;
        if (expected_q.size() == 0) begin
          if (fault_count_o < 10) begin
            $display("%0t: result transfer with nothing pending: pos %0d vel %0d snap %0b",
                     $realtime, got.position, got.velocity, got.snapped);
          end
          fault_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (want.position !== got.position || want.velocity !== got.velocity ||
              want.snapped !== got.snapped) begin
            if (fault_count_o < 10) begin
              $display("%0t: mismatch: expected pos %0d vel %0d snap %0b, got pos %0d vel %0d snap %0b",
                       $realtime, want.position, want.velocity, want.snapped,
                       got.position, got.velocity, got.snapped);
            end
            fault_count_o++;
          end
        end
      end
      if (item_i.valid && item_i.ready) begin
        want = smooth_step(fx_t'(item_i.current_position), fx_t'(item_i.goal_position),
                           fx_t'({40'd0, item_i.time_step}), fx_t'({40'd0, rate_q}),
                           held_velocity);
        held_velocity = fx_t'(want.velocity);
        expected_q.push_back(want);
      end
      outstanding_o = expected_q.size();
    end
  end

endmodule

// ----- verif/critically_damped_smoother_core_test.sv -----
`timescale 1ns / 1ps

module critically_damped_smoother_core_test;

  localparam int unsigned VW             = cds_pkg::DEF_VALUE_WIDTH;
  localparam int unsigned RW             = cds_pkg::RATE_WIDTH;
  localparam int unsigned STALL_MAX      = 18;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 120;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned PHASE_ITEMS    = 100;

  localparam logic signed [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] POS_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [RW-1:0]        RATE_MAX = '1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [RW-1:0]        cfg_wdata_i = '0;
  int unsigned          fault_count;
  int unsigned          outstanding;
  int unsigned          idle_cycles = 0;
  bit                   send_burst  = 1'b0;
  bit                   take_burst  = 1'b0;
  logic signed [VW-1:0] last_pos    = '0;

  cds_in_if  #(.VALUE_WIDTH(VW)) item_ch ();
  cds_out_if #(.VALUE_WIDTH(VW)) result_ch ();

  always #10 clk_i = ~clk_i;

  critically_damped_smoother_core #(
    .VALUE_WIDTH(VW),
    .FRAC_BITS  (cds_pkg::DEF_FRAC_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_ch),
    .result_o   (result_ch)
  );

  critically_damped_smoother_core_checker #(
    .VALUE_WIDTH(VW),
    .FRAC_BITS  (cds_pkg::DEF_FRAC_BITS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item_ch),
    .result_i     (result_ch),
    .fault_count_o(fault_count),
    .outstanding_o(outstanding)
  );

  function automatic int unsigned draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  // entered and left at a falling edge
  task automatic push_item(input logic signed [VW-1:0] cur, input logic signed [VW-1:0] goal,
                           input logic [RW-1:0] dt);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid            = 1'b1;
    item_ch.current_position = cur;
    item_ch.goal_position    = goal;
    item_ch.time_step        = dt;
    do @(posedge clk_i); while (!item_ch.ready);
    @(negedge clk_i);
  endtask

  // only once every result is back, so the block is idle
  task automatic write_rate(input logic [RW-1:0] rate);
    item_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = rate;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // result side: random stall per transfer, with stretches of none
  initial begin
    int unsigned stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      stall = draw_gap(take_burst);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      @(negedge clk_i);
    end
  end

  // closed loop: where the random phases reuse last_pos, the next position starts from the last one delivered
  always @(posedge clk_i) begin
    if (result_ch.valid && result_ch.ready) begin
      last_pos <= result_ch.new_position;
    end
  end

  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT - 1) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [RW-1:0]        rate;
    logic [RW-1:0]        dt;
    logic signed [VW-1:0] goal;
    logic signed [VW-1:0] cur;
    int unsigned          pick;
    item_ch.valid            = 1'b0;
    item_ch.current_position = '0;
    item_ch.goal_position    = '0;
    item_ch.time_step        = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // rate still zero after reset: goal passes straight through
    push_item(POS_MAX, POS_MIN, RATE_MAX);
    push_item(POS_MIN, POS_MAX, '0);
    push_item('0, '0, 24'h000100);

    write_rate(24'h020000);
    repeat (3) push_item('0, 10 <<< 16, 24'h001000);
    push_item(5 <<< 16, 5 <<< 16, 24'h001000);
    push_item(POS_MAX, POS_MIN, 24'h001000);
    push_item(POS_MIN, POS_MAX, 24'h001000);
    push_item(100 <<< 16, '0, '0);
    // huge omega*dt, reciprocal truncates to zero
    push_item('0, -(3 <<< 16), RATE_MAX);

    write_rate(RATE_MAX);
    push_item(1 <<< 16, '0, 24'h000001);
    push_item(POS_MIN, POS_MAX, RATE_MAX);
    push_item(-(7 <<< 16), 7 <<< 16, 24'h000400);

    write_rate(24'h000001);
    push_item(POS_MAX, '0, 24'h000001);
    push_item('0, 1, 24'h010000);

    // build up a velocity, then switch the spring off: it must be held and reported
    write_rate(24'h040000);
    repeat (2) push_item('0, 20 <<< 16, 24'h000800);
    write_rate('0);
    push_item(3 <<< 16, -(4 <<< 16), 24'h000800);

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: rate = RATE_MAX;
        1: rate = '0;
        2: rate = 24'h000001;
        default: begin
          if ($urandom_range(0, 3) == 0) rate = RW'($urandom_range(0, RATE_MAX));
          else rate = RW'($urandom_range(24'h004000, 24'h0C0000));
        end
      endcase
      write_rate(rate);
      goal = $signed($urandom) >>> $urandom_range(2, 12);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // tracking a goal that moves now and then
          if ($urandom_range(0, 14) == 0) goal = $signed($urandom) >>> $urandom_range(2, 12);
          cur = last_pos;
          dt  = RW'($urandom_range(24'h000100, 24'h002000));
        end else if (pick == 7) begin
          cur  = $urandom;
          goal = $urandom;
          dt   = RW'($urandom_range(0, RATE_MAX));
        end else if (pick == 8) begin
          // position jumps away from the track
          cur = $urandom;
          dt  = RW'($urandom_range(24'h000100, 24'h002000));
        end else begin
          cur = last_pos;
          dt  = ($urandom_range(0, 3) == 0) ? '0 : RATE_MAX;
        end
        push_item(cur, goal, dt);
      end
    end

    item_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
